// File: src/gnp_pkg.sv
// Shared types, constants and arithmetic helpers for the gnomonic projection unit.
// Used by the CORDIC and divider cells, the top level and the port checker.
package gnp_pkg;

    localparam int ANG_W = 36;   // reduced-angle working width, Q30
    localparam int CRD_W = 34;   // CORDIC x, y, z width, Q30
    localparam int DIV_STEPS = 32;

    localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [CRD_W-1:0] Q30_GAIN    = 34'sd652032874;
    localparam logic signed [63:0]      Q30_HALF    = 64'sd536870912;

    localparam logic [1:0] REG_CENTER_RA  = 2'd0;
    localparam logic [1:0] REG_CENTER_DEC = 2'd1;

    typedef struct packed {
        logic signed [31:0] ra;
        logic signed [31:0] dec;
    } gnp_in_t;

    typedef struct packed {
        logic signed [31:0] plane_x;
        logic signed [31:0] plane_y;
        logic               valid_res;
    } gnp_out_t;

    typedef struct packed {
        logic                    vld;
        logic                    neg;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } cord_t;

    typedef struct packed {
        logic        vld;
        logic        vres;
        logic        neg;
        logic        ovf;
        logic [32:0] d;
        logic [33:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } div_t;

    function automatic logic signed [CRD_W-1:0] stage_angle(input int i);
        logic signed [CRD_W-1:0] r;
        unique case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = (i < 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

    // Round a Q30 by Q30 product back to Q30
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b)) + Q30_HALF;
        p = p >>> 30;
        return p[31:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_down(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] r;
        r = a;
        for (int k = 0; k < 3; k++) begin
            if (r > Q30_PI)
                r = r - Q30_TWO_PI;
        end
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_up(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] r;
        r = a;
        for (int k = 0; k < 3; k++) begin
            if (r < -Q30_PI)
                r = r + Q30_TWO_PI;
        end
        return r;
    endfunction

    // Fold into [-pi/2, pi/2] and seed a CORDIC lane
    function automatic cord_t cord_seed(input logic v, input logic signed [ANG_W-1:0] a);
        cord_t c;
        logic signed [ANG_W-1:0] r;
        r = wrap_up(a);
        c.neg = 1'b0;
        if (r > Q30_HALF_PI) begin
            r = r - Q30_PI;
            c.neg = 1'b1;
        end
        else if (r < -Q30_HALF_PI) begin
            r = r + Q30_PI;
            c.neg = 1'b1;
        end
        c.vld = v;
        c.x = Q30_GAIN;
        c.y = '0;
        c.z = r[CRD_W-1:0];
        return c;
    endfunction

endpackage

// File: src/gnp_cordic_cell.sv
// One rotation-mode CORDIC stage, registered.
// Depends on gnp_pkg for the lane type and the stage angle table.
module gnp_cordic_cell
    import gnp_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cord_t din,
    output cord_t dout
);
    localparam logic signed [CRD_W-1:0] ANGLE = stage_angle(STAGE);

    cord_t nxt;

    always_comb
    begin
        nxt = din;
        if (din.z >= 0)
        begin
            nxt.x = din.x - (din.y >>> STAGE);
            nxt.y = din.y + (din.x >>> STAGE);
            nxt.z = din.z - ANGLE;
        end
        else
        begin
            nxt.x = din.x + (din.y >>> STAGE);
            nxt.y = din.y - (din.x >>> STAGE);
            nxt.z = din.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout <= '0;
        else
            dout <= nxt;
    end
endmodule

// File: src/gnp_div_cell.sv
// One restoring-division step: one quotient bit per cell, registered.
// Depends on gnp_pkg for the lane type.
module gnp_div_cell
    import gnp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  div_t din,
    output div_t dout
);
    div_t        nxt;
    logic [34:0] sh;
    logic        bit_q;

    always_comb
    begin
        nxt = din;
        sh = {din.rem, din.low[31]};
        bit_q = (sh >= {2'b00, din.d});
        if (bit_q)
            nxt.rem = 34'(sh - {2'b00, din.d});
        else
            nxt.rem = sh[33:0];
        nxt.low = {din.low[30:0], 1'b0};
        nxt.quo = {din.quo[30:0], bit_q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout <= '0;
        else
            dout <= nxt;
    end
endmodule

// File: src/gnomonic_forward_projection_unit.sv
// Top level: gnomonic tangent-plane projection, fully pipelined.
// Depends on gnp_pkg, gnp_cordic_cell and gnp_div_cell.
//
//  channel   signals                          transfer when
//  input     start, busy, item                start && !busy
//  result    done, result                     done (one cycle)
//  config    cfg_we, cfg_index, cfg_data      cfg_we
//
// One point per cycle; busy stays low. The pipeline runs through, in order:
// two angle-reduction stages, the CORDIC chain, three multiply stages, one
// divider setup stage, 32 divider cells and the output register.
// Reset clears the valid bits of every stage and the centre registers.
// The receiver cannot stall, so results leave as they finish.
module gnomonic_forward_projection_unit
    import gnp_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  gnp_in_t     item,
    output logic        done,
    output gnp_out_t    result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic signed [31:0] center_ra_reg, center_dec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_ra_reg  <= '0;
            center_dec_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_RA:  center_ra_reg  <= cfg_data;
                REG_CENTER_DEC: center_dec_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Angle reduction, first half
    logic                    r1_vld_reg;
    logic signed [ANG_W-1:0] r1_ra_reg, r1_dec_reg, r1_dec0_reg;
    logic signed [ANG_W-1:0] a_ra, a_dec, a_dec0;

    always_comb
    begin
        a_ra   = (ANG_W'(item.ra) - ANG_W'(center_ra_reg)) <<< 2;
        a_dec  = ANG_W'(item.dec) <<< 2;
        a_dec0 = ANG_W'(center_dec_reg) <<< 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r1_vld_reg <= 1'b0;
        else
            r1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        r1_ra_reg   <= wrap_down(a_ra);
        r1_dec_reg  <= wrap_down(a_dec);
        r1_dec0_reg <= wrap_down(a_dec0);
    end

    // CORDIC chains
    cord_t cra [CORDIC_STAGES+1];
    cord_t cdc [CORDIC_STAGES+1];
    cord_t cd0 [CORDIC_STAGES+1];
    cord_t seed_ra_reg, seed_dec_reg, seed_dec0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_ra_reg   <= '0;
            seed_dec_reg  <= '0;
            seed_dec0_reg <= '0;
        end
        else
        begin
            seed_ra_reg   <= cord_seed(r1_vld_reg, r1_ra_reg);
            seed_dec_reg  <= cord_seed(r1_vld_reg, r1_dec_reg);
            seed_dec0_reg <= cord_seed(r1_vld_reg, r1_dec0_reg);
        end
    end

    assign cra[0] = seed_ra_reg;
    assign cdc[0] = seed_dec_reg;
    assign cd0[0] = seed_dec0_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        gnp_cordic_cell #(.STAGE(g)) u_ra (
            .clk(clk), .rst_n(rst_n), .din(cra[g]), .dout(cra[g+1]));
        gnp_cordic_cell #(.STAGE(g)) u_dec (
            .clk(clk), .rst_n(rst_n), .din(cdc[g]), .dout(cdc[g+1]));
        gnp_cordic_cell #(.STAGE(g)) u_dec0 (
            .clk(clk), .rst_n(rst_n), .din(cd0[g]), .dout(cd0[g+1]));
    end

    logic signed [CRD_W-1:0] sr_w, cr_w, sd_w, cd_w, sd0_w, cd0_w;

    always_comb
    begin
        sr_w  = cra[CORDIC_STAGES].neg ? -cra[CORDIC_STAGES].y : cra[CORDIC_STAGES].y;
        cr_w  = cra[CORDIC_STAGES].neg ? -cra[CORDIC_STAGES].x : cra[CORDIC_STAGES].x;
        sd_w  = cdc[CORDIC_STAGES].neg ? -cdc[CORDIC_STAGES].y : cdc[CORDIC_STAGES].y;
        cd_w  = cdc[CORDIC_STAGES].neg ? -cdc[CORDIC_STAGES].x : cdc[CORDIC_STAGES].x;
        sd0_w = cd0[CORDIC_STAGES].neg ? -cd0[CORDIC_STAGES].y : cd0[CORDIC_STAGES].y;
        cd0_w = cd0[CORDIC_STAGES].neg ? -cd0[CORDIC_STAGES].x : cd0[CORDIC_STAGES].x;
    end

    // Products
    logic               m1_vld_reg, m2_vld_reg, m3_vld_reg;
    logic signed [31:0] m1_p1_reg, m1_p2_reg, m1_nx_reg, m1_p3_reg, m1_p4_reg, m1_cr_reg;
    logic signed [31:0] m2_p1_reg, m2_q1_reg, m2_nx_reg, m2_p3_reg, m2_q2_reg;
    logic signed [32:0] m3_cosc_reg, m3_ny_reg, m3_nx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= cra[CORDIC_STAGES].vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_p1_reg <= qmul(sd0_w[31:0], sd_w[31:0]);
        m1_p2_reg <= qmul(cd0_w[31:0], cd_w[31:0]);
        m1_nx_reg <= qmul(cd_w[31:0], sr_w[31:0]);
        m1_p3_reg <= qmul(cd0_w[31:0], sd_w[31:0]);
        m1_p4_reg <= qmul(sd0_w[31:0], cd_w[31:0]);
        m1_cr_reg <= cr_w[31:0];

        m2_p1_reg <= m1_p1_reg;
        m2_q1_reg <= qmul(m1_p2_reg, m1_cr_reg);
        m2_nx_reg <= m1_nx_reg;
        m2_p3_reg <= m1_p3_reg;
        m2_q2_reg <= qmul(m1_p4_reg, m1_cr_reg);

        m3_cosc_reg <= 33'(m2_p1_reg) + 33'(m2_q1_reg);
        m3_ny_reg   <= 33'(m2_p3_reg) - 33'(m2_q2_reg);
        m3_nx_reg   <= 33'(m2_nx_reg);
    end

    // Divider setup: |num| * 2^24 split into high part and shifted-in bits
    function automatic div_t div_seed(input logic v, input logic signed [32:0] num,
                                      input logic signed [32:0] den);
        div_t        s;
        logic [32:0] mag;
        mag = num[32] ? 33'(-num) : 33'(num);
        s.vld  = v;
        s.vres = !den[32] && (den != '0);
        s.neg  = num[32];
        s.d    = den;
        s.ovf  = {9'd0, mag[32:8]} >= {1'b0, den};
        s.rem  = {9'd0, mag[32:8]};
        s.low  = {mag[7:0], 24'd0};
        s.quo  = '0;
        return s;
    endfunction

    div_t dx [DIV_STEPS+1];
    div_t dy [DIV_STEPS+1];
    div_t seed_x_reg, seed_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_x_reg <= '0;
            seed_y_reg <= '0;
        end
        else
        begin
            seed_x_reg <= div_seed(m3_vld_reg, m3_nx_reg, m3_cosc_reg);
            seed_y_reg <= div_seed(m3_vld_reg, m3_ny_reg, m3_cosc_reg);
        end
    end

    assign dx[0] = seed_x_reg;
    assign dy[0] = seed_y_reg;

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        gnp_div_cell u_x (.clk(clk), .rst_n(rst_n), .din(dx[g]), .dout(dx[g+1]));
        gnp_div_cell u_y (.clk(clk), .rst_n(rst_n), .din(dy[g]), .dout(dy[g+1]));
    end

    function automatic logic signed [31:0] finish(input div_t s);
        logic signed [31:0] r;
        if (!s.vres)
            r = '0;
        else if (s.neg)
        begin
            if (s.ovf || s.quo > 32'h8000_0000)
                r = 32'sh8000_0000;
            else
                r = -$signed(s.quo);
        end
        else
        begin
            if (s.ovf || s.quo > 32'h7fff_ffff)
                r = 32'sh7fff_ffff;
            else
                r = $signed(s.quo);
        end
        return r;
    endfunction

    logic     done_reg;
    gnp_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dx[DIV_STEPS].vld && dy[DIV_STEPS].vld;
    end

    always_ff @(posedge clk)
    begin
        result_reg.plane_x   <= finish(dx[DIV_STEPS]);
        result_reg.plane_y   <= finish(dy[DIV_STEPS]);
        result_reg.valid_res <= dx[DIV_STEPS].vres;
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

// File: src/gnp_checker.sv
// Port-level checks for the projection unit, bound to the top level.
// Depends on gnp_pkg for the payload types.
module gnp_checker
    import gnp_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input gnp_out_t result
);
    localparam int LATENCY = CORDIC_STAGES + 39;

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input transfer");

    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("input transfer produced no result");

    a_far_side_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.valid_res) |-> (result.plane_x == 0 && result.plane_y == 0))
        else $error("far-side result carries nonzero coordinates");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
endmodule

bind gnomonic_forward_projection_unit gnp_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result));
